@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: label");
`define ASSERT_RST(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) (!rst_n) |-> (prop)) \
		else $error("reset check failed: label");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_RST(label, clk, rst_n, prop)
`endif
`endif

@@ rtl/core/s2h_pkg.sv @@
// ----------------------------------------------------------------------------
// s2h_pkg
// Shared constants for the single to half conversion.
// ----------------------------------------------------------------------------
`default_nettype none
package s2h_pkg;
	localparam int SINGLE_W = 32;
	localparam int HALF_W   = 16;
	localparam logic [7:0] EXP_SPECIAL  = 8'hFF;
	localparam logic [7:0] EXP_OVF_MAX  = 8'h8E;
	localparam logic [7:0] EXP_NORM_MIN = 8'h71;
	localparam logic [7:0] EXP_REBIAS   = 8'h70;
	localparam logic [4:0] HEXP_INF     = 5'h1F;
	localparam logic [9:0] QNAN_MAN     = 10'h200;
	localparam logic [4:0] SUB_SH_MAX   = 5'd24;
endpackage
`default_nettype wire

@@ rtl/core/s2h_conv.sv @@
// ----------------------------------------------------------------------------
// s2h_conv
// Combinational binary32 to binary16 conversion.
// ----------------------------------------------------------------------------
`default_nettype none
module s2h_conv (
	input  wire logic [s2h_pkg::SINGLE_W-1:0] single_bits,
	input  wire logic                         sub_en,
	output logic      [s2h_pkg::HALF_W-1:0]   half_bits
);
	logic        sgn;
	logic [7:0]  ex;
	logic [22:0] man;
	logic [14:0] h;
	logic [14:0] nrm;
	logic [7:0]  sh;
	logic [23:0] sig;
	logic [23:0] shifted;

	assign sgn = single_bits[31];
	assign ex  = single_bits[30:23];
	assign man = single_bits[22:0];
	assign sig = {1'b1, man};
	assign sh  = 8'd126 - ex;
	assign shifted = sig >> sh[4:0];
	assign nrm = {ex[4:0] - s2h_pkg::EXP_REBIAS[4:0], man[22:13]};

	always_comb begin
		if (ex == s2h_pkg::EXP_SPECIAL) begin
			if (man == '0)
				h = {s2h_pkg::HEXP_INF, 10'd0};
			else if (man[22:13] == '0)
				h = {s2h_pkg::HEXP_INF, s2h_pkg::QNAN_MAN};
			else
				h = {s2h_pkg::HEXP_INF, man[22:13]};
		end else if (ex > s2h_pkg::EXP_OVF_MAX) begin
			h = {s2h_pkg::HEXP_INF, 10'd0};
		end else if (ex < s2h_pkg::EXP_NORM_MIN) begin
			if (sub_en && sh < {3'd0, s2h_pkg::SUB_SH_MAX})
				h = {5'd0, shifted[9:0]};
			else
				h = '0;
		end else begin
			if (man[12] && ((man[11:0] != '0) || man[13]))
				h = nrm + 15'd1;
			else
				h = nrm;
		end
	end

	assign half_bits = {sgn, h};
endmodule
`default_nettype wire

@@ rtl/core/single_to_half_convert.sv @@
// ----------------------------------------------------------------------------
// single_to_half_convert
// Streams binary32 words in and binary16 words out, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// channel | dir | payload
// s_axis  | in  | tdata[31:0] single_bits
// m_axis  | out | tdata[15:0] half_bits
// cfg     | in  | cfg_wdata[0] subnormals_enabled
// One word per cycle unless the output stalls; an input register, then a result register.
// Conversion logic sits between the two registers.
// Reset clears the valid flags and sets subnormals_enabled to 1.
// A stalled output stalls the input stage only when both stages are full.
`default_nettype none
`include "assert_macros.svh"
module single_to_half_convert (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] single_bits
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata    // [15:0] half_bits
);
	logic        sub_en_q;
	logic        vld_s1;
	logic [31:0] dat_s1;
	logic        vld_s2;
	logic [15:0] dat_s2;
	logic [15:0] conv;
	logic        adv_s2;

	assign adv_s2        = !vld_s2 || m_axis_tready;
	assign s_axis_tready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_en_q <= 1'b1;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
		end else begin
			if (cfg_we)
				sub_en_q <= cfg_wdata;
			if (s_axis_tready)
				vld_s1 <= s_axis_tvalid;
			if (adv_s2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			dat_s1 <= s_axis_tdata;
		if (adv_s2 && vld_s1)
			dat_s2 <= conv;
	end

	s2h_conv u_conv (
		.single_bits(dat_s1),
		.sub_en     (sub_en_q),
		.half_bits  (conv)
	);

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = dat_s2;

	`ASSERT_CLK(a_hold_out, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
	`ASSERT_CLK(a_full_stall, clk, arst_n, (vld_s1 && vld_s2 && !m_axis_tready) |-> !s_axis_tready)
	`ASSERT_RST(a_rst_empty, clk, arst_n, !vld_s1 && !vld_s2)
endmodule
`default_nettype wire
